/* rtl/core/rcci_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray / cylinder cap intersection package
// Shared constants, register codes and bundle types of the cap test pipeline.
// ----------------------------------------------------------------------------
package rcci_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned TQW         = 32;
  localparam int unsigned KW          = 33;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_AXIS_X     = 3'd3,
    REG_AXIS_Y     = 3'd4,
    REG_AXIS_Z     = 3'd5,
    REG_CYL_HEIGHT = 3'd6,
    REG_CYL_RADIUS = 3'd7
  } cfg_reg_e;

  // Cap centers (index 0 is the top cap), radius and radius squared.
  typedef struct packed {
    logic [1:0][2:0][KW-1:0] k;
    logic [61:0]             rsq;
    logic [30:0]             r;
  } geom_t;

  // Ray data that travels beside the arithmetic.
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [31:0]      tlo;
    logic [31:0]      thi;
    logic             den_neg;
    logic [1:0]       num_neg;
  } side_t;

endpackage

/* rtl/core/rcci_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cylinder geometry setup
// Holds the configuration registers and derives the unit axis, the cap
// centers and the squared radius with a small sequencer after each write.
// ----------------------------------------------------------------------------
module rcci_setup
  import rcci_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_idx_i,
  input  logic [31:0]                 cfg_wdata_i,
  output logic                        busy_o,
  output logic signed [FRAC_BITS+1:0] u_o [3],
  output geom_t                       geom_o
);

  localparam int unsigned UW    = FRAC_BITS + 2;
  localparam int unsigned DvdW  = 32 + FRAC_BITS;
  localparam int unsigned DCntW = $clog2(DvdW);
  localparam int unsigned OffW  = UW + 31;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OFF  = 5'b10000
  } state_e;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  logic signed [31:0] center_q [3];
  logic signed [31:0] axis_q [3];
  logic [30:0]        height_q, radius_q;

  state_e             state_q, state_d;
  logic               dirty_q, dirty_d;
  logic [1:0]         idx_q, idx_d;
  logic [63:0]        n_q, n_d, root_q, root_d, bit_q, bit_d;
  logic [4:0]         rcnt_q, rcnt_d;
  logic [DvdW-1:0]    dvd_q, dvd_d;
  logic [31:0]        rem_q, rem_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [DCntW-1:0]   dcnt_q, dcnt_d;
  logic signed [UW-1:0] u_q [3];
  logic signed [UW-1:0] u_new;
  geom_t              geom_q, geom_d;

  logic [31:0]        amag;
  logic [63:0]        sq;
  logic [63:0]        trial;
  logic               rge;
  logic [32:0]        rtrial, len33;
  logic               dge;
  logic [FRAC_BITS:0] qfin;
  logic signed [OffW-1:0] offp;
  logic signed [KW-1:0]   off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '{default: '0};
      axis_q   <= '{32'sd0, 32'sd0, 32'sd65536};
      height_q <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:   center_q[0] <= cfg_wdata_i;
        REG_CENTER_Y:   center_q[1] <= cfg_wdata_i;
        REG_CENTER_Z:   center_q[2] <= cfg_wdata_i;
        REG_AXIS_X:     axis_q[0]   <= cfg_wdata_i;
        REG_AXIS_Y:     axis_q[1]   <= cfg_wdata_i;
        REG_AXIS_Z:     axis_q[2]   <= cfg_wdata_i;
        REG_CYL_HEIGHT: height_q    <= cfg_wdata_i[30:0];
        REG_CYL_RADIUS: radius_q    <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    amag   = mag32(axis_q[idx_q]);
    sq     = 64'(amag) * 64'(amag);
    trial  = root_q + bit_q;
    rge    = n_q >= trial;
    len33  = {1'b0, root_q[31:0]};
    rtrial = {rem_q, dvd_q[DvdW-1]};
    dge    = rtrial >= len33;
    qfin   = {quo_q, dge};
    if (root_q[31:0] == '0) begin
      u_new = '0;
    end else if (axis_q[idx_q][31]) begin
      u_new = -UW'(qfin);
    end else begin
      u_new = UW'(qfin);
    end
    offp = OffW'(u_q[idx_q]) * OffW'($signed({1'b0, height_q[30:1]}));
    off  = KW'(offp >>> FRAC_BITS);
  end

  always_comb begin
    state_d = state_q;
    dirty_d = dirty_q;
    idx_d   = idx_q;
    n_d     = n_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rcnt_d  = rcnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    geom_d  = geom_q;
    unique case (state_q)
      ST_IDLE: begin
        if (dirty_q) begin
          dirty_d = 1'b0;
          state_d = ST_SQ;
          idx_d   = '0;
          n_d     = '0;
        end
      end
      ST_SQ: begin
        n_d   = n_q + sq;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          state_d = ST_ROOT;
          bit_d   = 64'd1 << 62;
          root_d  = '0;
          rcnt_d  = '0;
        end
      end
      ST_ROOT: begin
        root_d = rge ? (root_q >> 1) + bit_q : root_q >> 1;
        n_d    = rge ? n_q - trial : n_q;
        bit_d  = bit_q >> 2;
        rcnt_d = rcnt_q + 5'd1;
        if (rcnt_q == 5'd31) begin
          state_d = ST_DIV;
          idx_d   = '0;
          dvd_d   = DvdW'(mag32(axis_q[0])) << FRAC_BITS;
          rem_d   = '0;
          quo_d   = '0;
          dcnt_d  = '0;
        end
      end
      ST_DIV: begin
        rem_d  = dge ? 32'(rtrial - len33) : rtrial[31:0];
        dvd_d  = dvd_q << 1;
        quo_d  = qfin[FRAC_BITS-1:0];
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCntW'(DvdW - 1)) begin
          if (idx_q == 2'd2) begin
            state_d = ST_OFF;
            idx_d   = '0;
          end else begin
            idx_d  = idx_q + 2'd1;
            dvd_d  = DvdW'(mag32(axis_q[2'(idx_q + 2'd1)])) << FRAC_BITS;
            rem_d  = '0;
            quo_d  = '0;
            dcnt_d = '0;
          end
        end
      end
      ST_OFF: begin
        geom_d.k[0][idx_q] = KW'(center_q[idx_q]) + off;
        geom_d.k[1][idx_q] = KW'(center_q[idx_q]) - off;
        geom_d.rsq = 62'(radius_q) * 62'(radius_q);
        geom_d.r   = radius_q;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dirty_q <= 1'b0;
      idx_q   <= '0;
      n_q     <= '0;
      root_q  <= '0;
      bit_q   <= '0;
      rcnt_q  <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
      u_q     <= '{UW'(0), UW'(0), UW'(1) << FRAC_BITS};
      geom_q  <= '0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      root_q  <= root_d;
      bit_q   <= bit_d;
      rcnt_q  <= rcnt_d;
      dvd_q   <= dvd_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      dcnt_q  <= dcnt_d;
      geom_q  <= geom_d;
      if (state_q == ST_DIV && dcnt_q == DCntW'(DvdW - 1)) begin
        u_q[idx_q] <= u_new;
      end
    end
  end

  assign busy_o = dirty_q | (state_q != ST_IDLE);
  assign u_o    = u_q;
  assign geom_o = geom_q;

endmodule

/* rtl/core/rcci_tdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray parameter divider
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared denominator, with an overflow flag per lane.
// ----------------------------------------------------------------------------
module rcci_tdiv
  import rcci_pkg::*;
#(
  parameter int unsigned NUM_W = 56,
  parameter int unsigned DEN_W = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i [2],
  input  logic [DEN_W-1:0] den_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [TQW-1:0]   quo_o [2],
  output logic             ovf_o [2],
  output side_t            side_o
);

  localparam int unsigned XW = (NUM_W > DEN_W + TQW) ? NUM_W : DEN_W + TQW;

  logic [TQW:0]       vld_q;
  logic [NUM_W-1:0]   rem_q [TQW+1][2];
  logic [TQW-1:0]     quo_q [TQW+1][2];
  logic               ovf_q [TQW+1][2];
  logic [DEN_W-1:0]   den_q [TQW+1];
  side_t              side_q [TQW+1];
  logic [XW-1:0]      shf [TQW][2];
  logic               ge [TQW][2];

  always_comb begin
    for (int s = 1; s <= TQW; s++) begin
      for (int c = 0; c < 2; c++) begin
        shf[s-1][c] = XW'(den_q[s-1]) << (TQW - s);
        ge[s-1][c]  = XW'(rem_q[s-1][c]) >= shf[s-1][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TQW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
    for (int c = 0; c < 2; c++) begin
      rem_q[0][c] <= num_i[c];
      quo_q[0][c] <= '0;
      ovf_q[0][c] <= XW'(num_i[c]) >= (XW'(den_i) << TQW);
    end
    for (int s = 1; s <= TQW; s++) begin
      den_q[s]  <= den_q[s-1];
      side_q[s] <= side_q[s-1];
      for (int c = 0; c < 2; c++) begin
        ovf_q[s][c] <= ovf_q[s-1][c];
        if (ge[s-1][c]) begin
          rem_q[s][c] <= NUM_W'(XW'(rem_q[s-1][c]) - shf[s-1][c]);
          quo_q[s][c] <= quo_q[s-1][c] | (TQW'(1) << (TQW - s));
        end else begin
          rem_q[s][c] <= rem_q[s-1][c];
          quo_q[s][c] <= quo_q[s-1][c];
        end
      end
    end
  end

  assign valid_o = vld_q[TQW];
  assign quo_o   = quo_q[TQW];
  assign ovf_o   = ovf_q[TQW];
  assign side_o  = side_q[TQW];

endmodule

/* rtl/core/ray_cylinder_cap_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray / cylinder cap intersection
// Tests each ray against both end-cap disks of the configured cylinder and
// returns the nearer hit with its point, normal and front-face flag.
// ----------------------------------------------------------------------------
// A ray is taken on every cycle in which start is high and busy is low, and
// its result appears with res_strobe_o, one result per ray, in order. The
// receiver cannot hold results off, so every strobed beat must be captured
// when it appears. Most of the pipeline lies in the 32-stage divider that
// forms the ray parameter of both caps. After any configuration write, busy
// stays high while the axis is normalized and the cap centers are derived.
// Values are Q16.16 at the default FRAC_BITS.
module ray_cylinder_cap_intersect
  import rcci_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] orig_x_i,
  input  logic signed [31:0] orig_y_i,
  input  logic signed [31:0] orig_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] t_lower_i,
  input  logic signed [31:0] t_upper_i,
  output logic               res_strobe_o,
  output logic               hit_o,
  output logic signed [31:0] t_hit_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o,
  output logic               front_face_o
);

  localparam int unsigned UW   = FRAC_BITS + 2;
  localparam int unsigned PdW  = 32 + UW;
  localparam int unsigned DenW = PdW + 2;
  localparam int unsigned PnW  = 34 + UW;
  localparam int unsigned NumW = PnW + 2;
  localparam int unsigned DqW  = DenW - FRAC_BITS;
  localparam int unsigned TW   = TQW + 1;
  localparam int unsigned MW   = 32 + TW;
  localparam int unsigned PW   = MW + 1 - FRAC_BITS;
  localparam int unsigned EW   = PW + 1;
  localparam int unsigned Lat  = TQW + 14;
  localparam logic signed [PW-1:0] PMax = PW'(signed'(32'h7fff_ffff));
  localparam logic signed [PW-1:0] PMin = PW'(signed'(32'h8000_0000));

  logic                 accept;
  logic signed [UW-1:0] u [3];
  geom_t                geom;

  logic [4:0] pre_vld_q;
  logic [7:0] post_vld_q;

  side_t                 sd1_q, sd2_q, sd3_q, sd4_q, sd5_q;
  logic signed [33:0]    dk2_q [2][3];
  logic signed [PdW-1:0] pd3_q [3];
  logic signed [PnW-1:0] pn3_q [2][3];
  logic signed [DenW-1:0] den4_q;
  logic signed [NumW-1:0] num4_q [2];
  logic [DenW-1:0]       den_mag;
  logic [NumW-1:0]       num_mag [2];
  logic [DqW-1:0]        dq5_q;
  logic [NumW-1:0]       nm5_q [2];

  logic                  dv_valid;
  logic [TQW-1:0]        dv_quo [2];
  logic                  dv_ovf [2];
  side_t                 dv_side;

  side_t                 sdA_q, sdB_q;
  logic signed [TW-1:0]  tA_q [2], tB_q [2], tC_q [2], tD_q [2], tE_q [2], tF_q [2];
  logic signed [TW-1:0]  tG_q [2];
  logic                  okA_q [2];
  logic                  inB_q [2], inC_q [2], inD_q [2], inE_q [2], inF_q [2];
  logic signed [MW-1:0]  mB_q [2][3];
  logic signed [PW-1:0]  pC_q [2][3];
  logic signed [EW-1:0]  eD_q [2][3];
  logic [EW-1:0]         e_mag [2][3];
  logic [31:0]           ptD_q [2][3], ptE_q [2][3], ptF_q [2][3], ptG_q [2][3];
  logic [30:0]           aE_q [2][3];
  logic                  ovE_q [2], ovF_q [2];
  logic [61:0]           sqF_q [2][3];
  logic [63:0]           dist_sum [2];
  logic                  hG_q [2];
  logic                  dnC_q, dnD_q, dnE_q, dnF_q, dnG_q;

  logic                  top_sel;
  logic                  any_hit;
  logic signed [31:0]    nrm [3];

  assign accept = start && !busy;

  rcci_setup #(
    .FRAC_BITS(FRAC_BITS)
  ) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .busy_o     (busy),
    .u_o        (u),
    .geom_o     (geom)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      post_vld_q <= '0;
    end else begin
      pre_vld_q  <= {pre_vld_q[3:0], accept};
      post_vld_q <= {post_vld_q[6:0], dv_valid};
    end
  end

  always_comb begin
    den_mag = den4_q[DenW-1] ? DenW'(-den4_q) : DenW'(den4_q);
    for (int c = 0; c < 2; c++) begin
      num_mag[c] = num4_q[c][NumW-1] ? NumW'(-num4_q[c]) : NumW'(num4_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    sd1_q.o       <= {orig_z_i, orig_y_i, orig_x_i};
    sd1_q.d       <= {dir_z_i, dir_y_i, dir_x_i};
    sd1_q.tlo     <= t_lower_i;
    sd1_q.thi     <= t_upper_i;
    sd1_q.den_neg <= 1'b0;
    sd1_q.num_neg <= '0;

    sd2_q <= sd1_q;
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 3; i++) begin
        dk2_q[c][i] <= 34'($signed(geom.k[c][i])) - 34'($signed(sd1_q.o[i]));
      end
    end

    sd3_q <= sd2_q;
    for (int i = 0; i < 3; i++) begin
      pd3_q[i] <= PdW'($signed(sd2_q.d[i])) * PdW'(u[i]);
      for (int c = 0; c < 2; c++) begin
        pn3_q[c][i] <= PnW'(dk2_q[c][i]) * PnW'(u[i]);
      end
    end

    sd4_q  <= sd3_q;
    den4_q <= DenW'(pd3_q[0]) + DenW'(pd3_q[1]) + DenW'(pd3_q[2]);
    for (int c = 0; c < 2; c++) begin
      num4_q[c] <= NumW'(pn3_q[c][0]) + NumW'(pn3_q[c][1]) + NumW'(pn3_q[c][2]);
    end

    sd5_q.o       <= sd4_q.o;
    sd5_q.d       <= sd4_q.d;
    sd5_q.tlo     <= sd4_q.tlo;
    sd5_q.thi     <= sd4_q.thi;
    sd5_q.den_neg <= den4_q[DenW-1];
    sd5_q.num_neg <= {num4_q[1][NumW-1], num4_q[0][NumW-1]};
    dq5_q         <= DqW'(den_mag >> FRAC_BITS);
    nm5_q         <= num_mag;
  end

  rcci_tdiv #(
    .NUM_W(NumW),
    .DEN_W(DqW)
  ) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(pre_vld_q[4]),
    .num_i  (nm5_q),
    .den_i  (dq5_q),
    .side_i (sd5_q),
    .valid_o(dv_valid),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf),
    .side_o (dv_side)
  );

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 3; i++) begin
        e_mag[c][i] = eD_q[c][i][EW-1] ? EW'(-eD_q[c][i]) : EW'(eD_q[c][i]);
      end
      dist_sum[c] = 64'(sqF_q[c][0]) + 64'(sqF_q[c][1]) + 64'(sqF_q[c][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    sdA_q <= dv_side;
    for (int c = 0; c < 2; c++) begin
      if (dv_side.num_neg[c] ^ dv_side.den_neg) begin
        tA_q[c] <= -TW'(dv_quo[c]);
      end else begin
        tA_q[c] <= TW'(dv_quo[c]);
      end
      okA_q[c] <= !dv_ovf[c];
    end

    sdB_q <= sdA_q;
    for (int c = 0; c < 2; c++) begin
      tB_q[c]  <= tA_q[c];
      inB_q[c] <= okA_q[c] && (tA_q[c] >= TW'($signed(sdA_q.tlo)))
                  && (tA_q[c] <= TW'($signed(sdA_q.thi)));
      for (int i = 0; i < 3; i++) begin
        mB_q[c][i] <= MW'($signed(sdA_q.d[i])) * MW'(tA_q[c]);
      end
    end

    dnC_q <= sdB_q.den_neg;
    for (int c = 0; c < 2; c++) begin
      tC_q[c]  <= tB_q[c];
      inC_q[c] <= inB_q[c];
      for (int i = 0; i < 3; i++) begin
        pC_q[c][i] <= PW'($signed(sdB_q.o[i])) + PW'(mB_q[c][i] >>> FRAC_BITS);
      end
    end

    dnD_q <= dnC_q;
    for (int c = 0; c < 2; c++) begin
      tD_q[c]  <= tC_q[c];
      inD_q[c] <= inC_q[c];
      for (int i = 0; i < 3; i++) begin
        eD_q[c][i] <= EW'(pC_q[c][i]) - EW'($signed(geom.k[c][i]));
        if (pC_q[c][i] > PMax) begin
          ptD_q[c][i] <= 32'h7fff_ffff;
        end else if (pC_q[c][i] < PMin) begin
          ptD_q[c][i] <= 32'h8000_0000;
        end else begin
          ptD_q[c][i] <= 32'(pC_q[c][i]);
        end
      end
    end

    dnE_q <= dnD_q;
    for (int c = 0; c < 2; c++) begin
      tE_q[c]  <= tD_q[c];
      inE_q[c] <= inD_q[c];
      ptE_q[c] <= ptD_q[c];
      ovE_q[c] <= (e_mag[c][0] > EW'(geom.r)) || (e_mag[c][1] > EW'(geom.r))
                  || (e_mag[c][2] > EW'(geom.r));
      for (int i = 0; i < 3; i++) begin
        aE_q[c][i] <= e_mag[c][i][30:0];
      end
    end

    dnF_q <= dnE_q;
    for (int c = 0; c < 2; c++) begin
      tF_q[c]  <= tE_q[c];
      inF_q[c] <= inE_q[c];
      ptF_q[c] <= ptE_q[c];
      ovF_q[c] <= ovE_q[c];
      for (int i = 0; i < 3; i++) begin
        sqF_q[c][i] <= 62'(aE_q[c][i]) * 62'(aE_q[c][i]);
      end
    end

    dnG_q <= dnF_q;
    for (int c = 0; c < 2; c++) begin
      tG_q[c]  <= tF_q[c];
      ptG_q[c] <= ptF_q[c];
      hG_q[c]  <= inF_q[c] && !ovF_q[c] && (dist_sum[c] <= 64'(geom.rsq));
    end
  end

  // A tie between the caps keeps the top cap. Both caps share one normal.
  always_comb begin
    top_sel = hG_q[0] && !(hG_q[1] && (tG_q[1] < tG_q[0]));
    any_hit = hG_q[0] || hG_q[1];
    for (int i = 0; i < 3; i++) begin
      nrm[i] = dnG_q ? 32'(u[i]) : -32'(u[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (any_hit) begin
      hit_o        <= 1'b1;
      t_hit_o      <= top_sel ? 32'(tG_q[0]) : 32'(tG_q[1]);
      point_x_o    <= top_sel ? ptG_q[0][0] : ptG_q[1][0];
      point_y_o    <= top_sel ? ptG_q[0][1] : ptG_q[1][1];
      point_z_o    <= top_sel ? ptG_q[0][2] : ptG_q[1][2];
      normal_x_o   <= nrm[0];
      normal_y_o   <= nrm[1];
      normal_z_o   <= nrm[2];
      front_face_o <= top_sel ? dnG_q : !dnG_q;
    end else begin
      hit_o        <= 1'b0;
      t_hit_o      <= '0;
      point_x_o    <= '0;
      point_y_o    <= '0;
      point_z_o    <= '0;
      normal_x_o   <= '0;
      normal_y_o   <= '0;
      normal_z_o   <= '0;
      front_face_o <= 1'b0;
    end
  end

  assign res_strobe_o = post_vld_q[7];

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Lat res_strobe_o)
    else $error("accepted ray produced no result beat at the fixed latency");

  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("busy not raised after a configuration write");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> !$past(cfg_we_i))
    else $error("busy dropped right after a configuration write");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cylinder cap intersection testbench
// Sends rays to the cap test, predicts each result in wide integer
// arithmetic, and checks every strobed result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rcci_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t, px, py, pz, nx, ny, nz;
    logic               front;
  } cap_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] orig_x_i = '0, orig_y_i = '0, orig_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [31:0] t_lower_i = '0, t_upper_i = '0;
  logic               res_strobe_o, hit_o, front_face_o;
  logic signed [31:0] t_hit_o, point_x_o, point_y_o, point_z_o;
  logic signed [31:0] normal_x_o, normal_y_o, normal_z_o;

  ray_cylinder_cap_intersect DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  wide_t       cyl_center [3];
  wide_t       cyl_axis [3];
  wide_t       cyl_height, cyl_radius;
  cap_result_t pending_hits [$];
  int          mismatches = 0;
  int          rays_sent = 0;
  int          hits_seen = 0;
  int          beats_seen = 0;
  bit          idle_en = 1'b1;

  function automatic wide_t isqrt_wide(wide_t n);
    wide_t r, b;
    r = 0;
    b = wide_t'(1) <<< 124;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic bit disk_test(vec3_t k, vec3_t o, vec3_t d, vec3_t u, wide_t dq,
                                   wide_t tlo, wide_t thi, output wide_t t_out,
                                   output vec3_t p);
    wide_t num, dist2, df;
    num = 0;
    dist2 = 0;
    for (int i = 0; i < 3; i++) num += (k[i] - o[i]) * u[i];
    t_out = num / dq;
    for (int i = 0; i < 3; i++) begin
      p[i] = o[i] + ((d[i] * t_out) >>> FracBitsDef);
      df = p[i] - k[i];
      dist2 += df * df;
    end
    if (t_out < tlo || t_out > thi) return 1'b0;
    return dist2 <= cyl_radius * cyl_radius;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic cap_result_t predict_cap_hit(ray_t r);
    vec3_t       o, d, u, kt, kb, pt, pb, p, n;
    wide_t       len, den, dq, h2, off, tt, tb, tlo, thi, len2;
    bit          ht, hb, front, top;
    cap_result_t res;
    res = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    tlo = r.tlo;
    thi = r.thi;
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += cyl_axis[i] * cyl_axis[i];
    len = isqrt_wide(len2);
    if (len == 0) return res;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = (cyl_axis[i] <<< FracBitsDef) / len;
      den += d[i] * u[i];
    end
    dq = den / (wide_t'(1) <<< FracBitsDef);
    if (dq == 0) return res;
    h2 = cyl_height >>> 1;
    for (int i = 0; i < 3; i++) begin
      off = (u[i] * h2) >>> FracBitsDef;
      kt[i] = cyl_center[i] + off;
      kb[i] = cyl_center[i] - off;
    end
    ht = disk_test(kt, o, d, u, dq, tlo, thi, tt, pt);
    hb = disk_test(kb, o, d, u, dq, tlo, thi, tb, pb);
    if (ht && !(hb && tb < tt)) begin
      top = 1'b1;
      front = den < 0;
    end else if (hb) begin
      top = 1'b0;
      front = den > 0;
    end else begin
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      p[i] = top ? pt[i] : pb[i];
      n[i] = (top == front) ? u[i] : -u[i];
    end
    res.hit = 1'b1;
    res.t = top ? tt[31:0] : tb[31:0];
    res.px = sat32(p[0]); res.py = sat32(p[1]); res.pz = sat32(p[2]);
    res.nx = n[0][31:0]; res.ny = n[1][31:0]; res.nz = n[2][31:0];
    res.front = front;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", name, exp, got);
    end
  endfunction

  always @(posedge clk_i) begin
    cap_result_t exp;
    if (rst_ni && res_strobe_o) begin
      beats_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result beat with nothing expected");
      end else begin
        exp = pending_hits.pop_front();
        if (exp.hit) hits_seen++;
        check_field("hit", exp.hit, hit_o);
        check_field("t_hit", exp.t, t_hit_o);
        check_field("point_x", exp.px, point_x_o);
        check_field("point_y", exp.py, point_y_o);
        check_field("point_z", exp.pz, point_z_o);
        check_field("normal_x", exp.nx, normal_x_o);
        check_field("normal_y", exp.ny, normal_y_o);
        check_field("normal_z", exp.nz, normal_z_o);
        check_field("front_face", exp.front, front_face_o);
      end
    end
  end

  // Called and returning at a falling edge; start is left high for a following ray.
  task automatic send_ray(ray_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    {orig_x_i, orig_y_i, orig_z_i, dir_x_i, dir_y_i, dir_z_i, t_lower_i, t_upper_i} = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    pending_hits.push_back(predict_cap_hit(r));
    rays_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    case (idx)
      REG_CENTER_X:   cyl_center[0] = $signed(v);
      REG_CENTER_Y:   cyl_center[1] = $signed(v);
      REG_CENTER_Z:   cyl_center[2] = $signed(v);
      REG_AXIS_X:     cyl_axis[0] = $signed(v);
      REG_AXIS_Y:     cyl_axis[1] = $signed(v);
      REG_AXIS_Z:     cyl_axis[2] = $signed(v);
      REG_CYL_HEIGHT: cyl_height = wide_t'(v[30:0]);
      default:        cyl_radius = wide_t'(v[30:0]);
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_cylinder(logic [31:0] cx, cy, cz, ax, ay, az, h, rad);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_CYL_HEIGHT, h);
    write_reg(REG_CYL_RADIUS, rad);
  endtask

  function automatic logic signed [31:0] rand_fx(int unsigned span);
    return $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  // Ray from near the cylinder center, with a random direction and interval.
  function automatic ray_t aimed_ray();
    ray_t r;
    r.ox = cyl_center[0][31:0] + rand_fx(32'h80000);
    r.oy = cyl_center[1][31:0] + rand_fx(32'h80000);
    r.oz = cyl_center[2][31:0] + rand_fx(32'h80000);
    r.dx = rand_fx(32'h20000);
    r.dy = rand_fx(32'h20000);
    r.dz = rand_fx(32'h20000);
    r.tlo = rand_fx(32'h40000);
    r.thi = $signed($urandom_range(0, 32'h400000)) - 32'sh10000;
    return r;
  endfunction

  task automatic test_reset_defaults;
    ray_t r;
    cyl_center = '{0, 0, 0};
    cyl_axis = '{0, 0, 65536};
    cyl_height = 0;
    cyl_radius = 0;
    r = '{ox: 0, oy: 0, oz: 32'sh50000, dx: 0, dy: 0, dz: -32'sh10000,
          tlo: 0, thi: 32'sh7fffffff};
    send_ray(r);
    for (int i = 0; i < 3; i++) send_ray(aimed_ray());
  endtask

  task automatic test_directed;
    ray_t r;
    set_cylinder(0, 0, 0, 0, 0, 32'h10000, 32'h20000, 32'h10000);
    r = '{ox: 0, oy: 0, oz: 32'sh50000, dx: 0, dy: 0, dz: -32'sh10000,
          tlo: 0, thi: 32'sh7fffffff};
    send_ray(r);
    r.oz = -32'sh50000; r.dz = 32'sh10000;
    send_ray(r);
    r.oz = 0;
    send_ray(r);
    r.dz = 32'sh10000; r.dx = 32'sh10000; r.dz = 0;
    send_ray(r);
    r = '{ox: 0, oy: 0, oz: 32'sh50000, dx: 0, dy: 0, dz: -32'sh10000,
          tlo: 32'sh40000, thi: 32'sh30000};
    send_ray(r);
    r.tlo = 32'sh40000; r.thi = 32'sh40000;
    send_ray(r);
    r.ox = 32'sh10000; r.tlo = 0; r.thi = 32'sh7fffffff;
    send_ray(r);
    r.ox = 32'sh10001;
    send_ray(r);
    r = '{ox: 32'sh7fffffff, oy: 32'sh80000000, oz: 32'sh7fffffff, dx: 32'sh7fffffff,
          dy: 32'sh80000000, dz: 32'sh80000000, tlo: 32'sh80000000, thi: 32'sh7fffffff};
    send_ray(r);
    r = '{ox: 32'sh7fff0000, oy: 0, oz: 32'sh10000, dx: 32'sh7fffffff, dy: 0,
          dz: -32'sh1, tlo: 32'sh80000000, thi: 32'sh7fffffff};
    send_ray(r);
    set_cylinder(0, 0, 0, 0, 0, 32'h10000, 0, 32'h7fffffff);
    r = '{ox: 0, oy: 0, oz: 32'sh50000, dx: 32'sh7fffffff, dy: 0, dz: -32'sh10000,
          tlo: 32'sh80000000, thi: 32'sh7fffffff};
    send_ray(r);
    r.dz = 32'sh10000;
    send_ray(r);
    set_cylinder(0, 0, 0, 0, 0, 0, 32'h20000, 32'h10000);
    r = '{ox: 0, oy: 0, oz: 32'sh50000, dx: 0, dy: 0, dz: -32'sh10000,
          tlo: 0, thi: 32'sh7fffffff};
    send_ray(r);
    set_cylinder(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_ray(r);
    for (int i = 0; i < 6; i++) send_ray(noise_ray());
  endtask

  task automatic test_random_cylinders;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6)
        set_cylinder(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, $urandom_range(0, 32'h7fffffff),
                     $urandom_range(0, 32'h7fffffff));
      else
        set_cylinder(rand_fx(32'h640000), rand_fx(32'h640000), rand_fx(32'h640000),
                     rand_fx(32'h40000), rand_fx(32'h40000), rand_fx(32'h40000),
                     $urandom_range(0, 32'h80000), $urandom_range(0, 32'h40000));
      if (ph == 7) idle_en = 1'b0;
      for (int i = 0; i < 210; i++) begin
        if ($urandom_range(0, 3) == 0) send_ray(noise_ray());
        else send_ray(aimed_ray());
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_cylinders();
    start = 1'b0;
    for (int w = 0; w < 1000 && pending_hits.size() != 0; w++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d rays over thirteen cylinder setups; %0d result beats, %0d cap hits.",
             rays_sent, beats_seen, hits_seen);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("PASS ray_cylinder_cap_intersect");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_hits.size());
      $display("FAIL ray_cylinder_cap_intersect");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL ray_cylinder_cap_intersect");
    $finish;
  end

endmodule
